// ===== sv/bti_pkg.sv =====
// Package for the battery table interpolator: sizes, command codes and state types.
`default_nettype none
package bti_pkg;
  localparam int unsigned ChargePoints = 16;
  localparam int unsigned HealthPoints = 8;
  localparam int unsigned CiW = 4;
  localparam int unsigned HiW = 3;
  localparam int unsigned CellW = HiW + CiW;

  typedef enum logic [2:0] {
    CMD_LOAD_CHARGE = 3'd0,
    CMD_LOAD_HEALTH = 3'd1,
    CMD_LOAD_TABLE  = 3'd2,
    CMD_FORWARD     = 3'd3,
    CMD_INVERSE     = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    CLAMP_NONE = 2'd0,
    CLAMP_LOW  = 2'd1,
    CLAMP_HIGH = 2'd2
  } clamp_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_HREAD, ST_HSCAN, ST_XREAD, ST_XSCAN, ST_SEG,
    ST_DIVSET, ST_DIV, ST_FIN, ST_OUT
  } state_e;

  // Control from the top level to the divider and status back.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;
endpackage
`default_nettype wire

// ===== sv/bti_divider.sv =====
// Restoring serial divider: signed 50-bit dividend by signed 26-bit divisor, truncating.
`default_nettype none
module bti_divider (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bti_pkg::div_ctl_t  ctl_i,
  input  wire logic signed [49:0] num_i,
  input  wire logic signed [25:0] den_i,
  output bti_pkg::div_sts_t       sts_o,
  output logic signed [49:0]      quo_o
);
  import bti_pkg::*;

  logic [49:0] quo_q, quo_d;
  logic [25:0] rem_q, rem_d, den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [26:0] trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[49]} - {1'b0, den_q};
    if (ctl_i.start) begin
      quo_d  = num_i[49] ? 50'(-num_i) : num_i;
      den_d  = den_i[25] ? 26'(-den_i) : den_i;
      rem_d  = '0;
      cnt_d  = 6'd50;
      neg_d  = num_i[49] ^ den_i[25];
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[26]) begin
        rem_d = trial[25:0];
        quo_d = {quo_q[48:0], 1'b1};
      end else begin
        rem_d = {rem_q[24:0], quo_q[49]};
        quo_d = {quo_q[48:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quo_o = neg_q ? 50'(-quo_q) : quo_q;
endmodule
`default_nettype wire

// ===== sv/battery_table_interpolator.sv =====
// Top level: table and breakpoint memories, row and segment scans, result register.
// A load is written to memory when it is accepted. A query runs the health scan, the
// charge scan (one breakpoint read at a time), segment setup, the 50-step serial
// divider with its start and done signals, then the result clamp and the output.
// Clamped or flat segments skip the divider. One item is worked at a time; a waiting
// result holds back only a finished query. Reset clears control state, not memories.
`default_nettype none
module battery_table_interpolator (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         command_i,
  input  wire logic [2:0]         health_index_i,
  input  wire logic [3:0]         charge_index_i,
  input  wire logic signed [23:0] load_value_i,
  input  wire logic signed [23:0] query_x_i,
  input  wire logic [15:0]        query_health_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [23:0]      result_value_o,
  output logic [2:0]              row_used_o,
  output logic [1:0]              end_clamped_o
);
  import bti_pkg::*;

  // Breakpoint memory holds charge breaks at 0..15 and health breaks at 16..23.
  logic [15:0]        brk_mem [0:ChargePoints+HealthPoints-1];
  logic signed [23:0] tbl_mem [0:(1<<CellW)-1];
  logic [4:0]         brk_ra;
  logic [CellW-1:0]   tbl_ra;
  logic [15:0]        brk_rd;
  logic signed [23:0] tbl_rd;

  state_e state_q, state_d;
  logic             inv_q, inv_d;
  logic signed [23:0] qx_q, qx_d;
  logic [15:0]      qh_q, qh_d;
  logic [HiW:0]     idx_q, idx_d;        // scan index, one bit wider for the end
  logic [HiW-1:0]   row_q, row_d;
  logic [16:0]      best_q, best_d;
  logic [CiW:0]     col_q, col_d;
  logic signed [24:0] x0_q, x0_d, y0_q, y0_d, x1_q, x1_d, y1_q, y1_d;
  logic             found_q, found_d;
  logic [1:0]       clamp_q, clamp_d;
  logic signed [49:0] num_q, num_d;
  logic signed [25:0] den_q, den_d;
  logic signed [25:0] res_q, res_d;
  logic             ov_q, ov_d;
  logic signed [23:0] rv_q, rv_d;
  logic [2:0]       ru_q, ru_d;
  logic [1:0]       ec_q, ec_d;
  div_ctl_t         dctl;
  div_sts_t         dsts;
  logic signed [49:0] quo;
  logic             acc;
  logic signed [24:0] xv, yv;
  logic [16:0]      hdist;
  logic signed [26:0] resw;

  // The result register parts the two sides: a waiting result stalls only at ST_OUT.
  assign in_ready_o = (state_q == ST_IDLE);
  assign acc = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (acc && command_i == CMD_LOAD_CHARGE)
      brk_mem[{1'b0, charge_index_i}] <= load_value_i[15:0];
    if (acc && command_i == CMD_LOAD_HEALTH)
      brk_mem[5'(ChargePoints) + 5'(health_index_i)] <= load_value_i[15:0];
    if (acc && command_i == CMD_LOAD_TABLE)
      tbl_mem[{health_index_i, charge_index_i}] <= load_value_i;
    brk_rd <= brk_mem[brk_ra];
    tbl_rd <= tbl_mem[tbl_ra];
  end

  // Forward uses charge breaks as x, inverse uses the row entries.
  assign xv = inv_q ? 25'(tbl_rd) : $signed({9'd0, brk_rd});
  assign yv = inv_q ? $signed({9'd0, brk_rd}) : 25'(tbl_rd);
  assign hdist = ({1'b0, qh_q} >= {1'b0, brk_rd}) ? 17'(qh_q - brk_rd) : 17'(brk_rd - qh_q);

  bti_divider u_div (
    .clk_i, .rst_ni, .ctl_i(dctl), .num_i(num_q), .den_i(den_q), .sts_o(dsts), .quo_o(quo)
  );

  always_comb begin
    state_d = state_q; inv_d = inv_q; qx_d = qx_q; qh_d = qh_q; idx_d = idx_q;
    row_d = row_q; best_d = best_q; col_d = col_q; x0_d = x0_q; y0_d = y0_q;
    x1_d = x1_q; y1_d = y1_q; found_d = found_q; clamp_d = clamp_q; num_d = num_q;
    den_d = den_q; res_d = res_q; ov_d = ov_q; rv_d = rv_q; ru_d = ru_q; ec_d = ec_q;
    brk_ra = 5'(ChargePoints) + 5'(idx_q[HiW-1:0]);
    tbl_ra = {row_q, col_q[CiW-1:0]};
    dctl.start = 1'b0;
    resw = '0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (acc && (command_i == CMD_FORWARD || command_i == CMD_INVERSE)) begin
          inv_d = (command_i == CMD_INVERSE);
          qx_d = query_x_i; qh_d = query_health_i;
          idx_d = '0; row_d = '0;
          state_d = ST_HREAD;
        end
      end
      ST_HREAD: state_d = ST_HSCAN;
      ST_HSCAN: begin
        // First and last rows clamp; interior picks strictly smaller distance.
        if (idx_q == '0) begin
          best_d = hdist; row_d = '0;
          if (qh_q <= brk_rd) begin
            idx_d = '0; state_d = ST_XREAD;
          end else begin
            idx_d = (HiW+1)'(HealthPoints - 1); state_d = ST_HREAD;
          end
        end else if (idx_q == (HiW+1)'(HealthPoints - 1) && !best_q[16]) begin
          if (qh_q >= brk_rd) begin
            row_d = HiW'(HealthPoints - 1); state_d = ST_XREAD; idx_d = '0;
          end else begin
            // Interior pass: keep the row zero distance and mark the pass in the top bit.
            best_d = best_q | 17'h10000; idx_d = (HiW+1)'(1); state_d = ST_HREAD;
          end
        end else begin
          if (hdist < {1'b0, best_q[15:0]}) begin
            best_d = {1'b1, hdist[15:0]}; row_d = idx_q[HiW-1:0];
          end
          if (idx_q == (HiW+1)'(HealthPoints - 1)) begin
            state_d = ST_XREAD; idx_d = '0;
          end else begin
            idx_d = idx_q + 1'b1; state_d = ST_HREAD;
          end
        end
        if (state_d == ST_XREAD) begin
          col_d = '0; found_d = 1'b0;
        end
      end
      ST_XREAD: begin
        brk_ra = {1'b0, col_q[CiW-1:0]};
        state_d = ST_XSCAN;
      end
      ST_XSCAN: begin
        x1_d = xv; y1_d = yv;
        if (col_q == '0) begin
          x0_d = xv; y0_d = yv;
          if (25'(qx_q) <= xv) begin
            res_d = 26'(yv); clamp_d = CLAMP_LOW; state_d = ST_FIN;
          end else begin
            col_d = (CiW+1)'(ChargePoints - 1); state_d = ST_XREAD;
          end
        end else if (col_q == (CiW+1)'(ChargePoints - 1) && !found_q) begin
          if (25'(qx_q) >= xv) begin
            res_d = 26'(yv); clamp_d = CLAMP_HIGH; state_d = ST_FIN;
          end else begin
            found_d = 1'b1; col_d = (CiW+1)'(1); state_d = ST_XREAD;
          end
        end else begin
          if (25'(qx_q) >= x0_q && 25'(qx_q) <= xv) begin
            clamp_d = CLAMP_NONE; state_d = ST_SEG;
          end else if (col_q == (CiW+1)'(ChargePoints - 1)) begin
            res_d = 26'(yv); clamp_d = CLAMP_HIGH; state_d = ST_FIN;
          end else begin
            x0_d = xv; y0_d = yv; col_d = col_q + 1'b1; state_d = ST_XREAD;
          end
        end
      end
      ST_SEG: begin
        if (x1_q == x0_q) begin
          res_d = 26'(y0_q); state_d = ST_FIN;
        end else begin
          num_d = 50'(26'(25'(qx_q) - x0_q)) * 50'(26'(y1_q - y0_q));
          den_d = 26'(x1_q - x0_q);
          state_d = ST_DIVSET;
        end
      end
      ST_DIVSET: begin
        dctl.start = 1'b1; state_d = ST_DIV;
      end
      ST_DIV: begin
        if (dsts.done) begin
          res_d = 26'(y0_q) + 26'(quo); state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        resw = 27'(res_q);
        if (inv_q) begin
          if (res_q < 0) resw = '0;
          else if (res_q > 26'sd32768) resw = 27'sd32768;
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_q) begin
          rv_d = 24'(res_q); ru_d = row_q; ec_d = clamp_q; ov_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_FIN) res_d = 26'(resw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inv_q <= inv_d; qx_q <= qx_d; qh_q <= qh_d; idx_q <= idx_d; row_q <= row_d;
    best_q <= best_d; col_q <= col_d; x0_q <= x0_d; y0_q <= y0_d; x1_q <= x1_d;
    y1_q <= y1_d; found_q <= found_d; clamp_q <= clamp_d; num_q <= num_d;
    den_q <= den_d; res_q <= res_d; rv_q <= rv_d; ru_q <= ru_d; ec_q <= ec_d;
  end

  assign out_valid_o    = ov_q;
  assign result_value_o = rv_q;
  assign row_used_o     = ru_q;
  assign end_clamped_o  = ec_q;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ready_o) else $error("accepted while busy");
  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dsts.busy |-> (state_q == ST_DIV)) else $error("divider busy outside divide");
  a_clamp_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (end_clamped_o != 2'd3)) else $error("bad clamp code");
`endif
endmodule
`default_nettype wire

// ===== sim/battery_table_interpolator_checker.sv =====
// Checker for the battery table interpolator: shadow tables, result prediction, comparison.
`default_nettype none
module battery_table_interpolator_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic [2:0]         command_i,
  input  wire logic [2:0]         health_index_i,
  input  wire logic [3:0]         charge_index_i,
  input  wire logic signed [23:0] load_value_i,
  input  wire logic signed [23:0] query_x_i,
  input  wire logic [15:0]        query_health_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic signed [23:0] result_value_i,
  input  wire logic [2:0]         row_used_i,
  input  wire logic [1:0]         end_clamped_i,
  output int                      fail_count_o,
  output int                      pending_o
);
  import bti_pkg::*;

  typedef struct packed {
    logic signed [23:0] value;
    logic [2:0]         row;
    logic [1:0]         clamp;
  } lookup_t;

  logic [15:0]        charge_bp [ChargePoints];
  logic [15:0]        health_bp [HealthPoints];
  logic signed [23:0] cells [HealthPoints * ChargePoints];
  lookup_t            lookups_due [$];

  function automatic logic [2:0] pick_row(input longint h);
    longint best, d;
    int k;
    k = 0;
    if (h <= health_bp[0]) return 3'd0;
    if (h >= health_bp[HealthPoints - 1]) return 3'(HealthPoints - 1);
    best = h - health_bp[0];
    if (best < 0) best = -best;
    for (int i = 1; i < HealthPoints; i++) begin
      d = h - health_bp[i];
      if (d < 0) d = -d;
      if (d < best) begin
        best = d;
        k = i;
      end
    end
    return k[2:0];
  endfunction

  function automatic lookup_t predict_lookup(input logic [2:0] cmd, input longint qx,
                                              input longint qh);
    longint xs [ChargePoints];
    longint ys [ChargePoints];
    longint res, dx;
    lookup_t r;
    logic done;
    r.row = pick_row(qh);
    done = 1'b0;
    for (int i = 0; i < ChargePoints; i++) begin
      xs[i] = (cmd == CMD_FORWARD) ? longint'(charge_bp[i]) : longint'(cells[r.row * ChargePoints + i]);
      ys[i] = (cmd == CMD_FORWARD) ? longint'(cells[r.row * ChargePoints + i]) : longint'(charge_bp[i]);
    end
    if (qx <= xs[0]) begin
      res = ys[0];
      r.clamp = CLAMP_LOW;
    end else if (qx >= xs[ChargePoints - 1]) begin
      res = ys[ChargePoints - 1];
      r.clamp = CLAMP_HIGH;
    end else begin
      res = ys[ChargePoints - 1];
      r.clamp = CLAMP_HIGH;
      for (int i = 0; i + 1 < ChargePoints; i++) begin
        if (!done && qx >= xs[i] && qx <= xs[i + 1]) begin
          dx = xs[i + 1] - xs[i];
          // A flat segment returns its lower y instead of dividing.
          res = (dx == 0) ? ys[i] : ys[i] + ((qx - xs[i]) * (ys[i + 1] - ys[i])) / dx;
          r.clamp = CLAMP_NONE;
          done = 1'b1;
        end
      end
    end
    if (cmd == CMD_INVERSE) begin
      if (res < 0) res = 0;
      if (res > 32768) res = 32768;
    end
    r.value = res[23:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t e;
    if (!rst_ni) begin
      fail_count_o = 0;
      lookups_due.delete();
      pending_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        case (command_i)
          CMD_LOAD_CHARGE: charge_bp[charge_index_i] = load_value_i[15:0];
          CMD_LOAD_HEALTH: health_bp[health_index_i] = load_value_i[15:0];
          CMD_LOAD_TABLE:  cells[{health_index_i, charge_index_i}] = load_value_i;
          CMD_FORWARD, CMD_INVERSE:
            lookups_due.push_back(predict_lookup(command_i, query_x_i, query_health_i));
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (lookups_due.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result value %0d row %0d clamp %0d", $time,
                   result_value_i, row_used_i, end_clamped_i);
        end else begin
          e = lookups_due.pop_front();
          if (e.value !== result_value_i || e.row !== row_used_i ||
              e.clamp !== end_clamped_i) begin
            fail_count_o++;
            $display("%0t: expected value %0d row %0d clamp %0d, got %0d %0d %0d", $time,
                     e.value, e.row, e.clamp, result_value_i, row_used_i, end_clamped_i);
          end
        end
      end
      pending_o = lookups_due.size();
    end
  end
endmodule
`default_nettype wire

// ===== sim/battery_table_interpolator_tb.sv =====
// Testbench top: drives loads and lookups into the interpolator and gives the verdict.
`default_nettype none
module battery_table_interpolator_tb;
  import bti_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         command;
  logic [2:0]         health_index;
  logic [3:0]         charge_index;
  logic signed [23:0] load_value;
  logic signed [23:0] query_x;
  logic [15:0]        query_health;
  logic               out_valid;
  logic               out_ready;
  logic signed [23:0] result_value;
  logic [2:0]         row_used;
  logic [1:0]         end_clamped;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles;
  int                 hold_requests;

  // Largest stretch of cycles with no transfer on either channel before giving up.
  localparam int IdleLimit = 20000;

  battery_table_interpolator dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .command_i(command), .health_index_i(health_index), .charge_index_i(charge_index),
    .load_value_i(load_value), .query_x_i(query_x), .query_health_i(query_health),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .result_value_o(result_value), .row_used_o(row_used), .end_clamped_o(end_clamped)
  );

  battery_table_interpolator_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .command_i(command), .health_index_i(health_index), .charge_index_i(charge_index),
    .load_value_i(load_value), .query_x_i(query_x), .query_health_i(query_health),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .result_value_i(result_value), .row_used_i(row_used), .end_clamped_i(end_clamped),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Offers one item at the falling edge and holds it until the transfer happens.
  task automatic send_item(input logic [2:0] cmd, input logic [2:0] hi, input logic [3:0] ci,
                           input logic [23:0] lv, input logic [23:0] qx, input logic [15:0] qh);
    in_valid     <= 1'b1;
    command      <= cmd;
    health_index <= hi;
    charge_index <= ci;
    load_value   <= lv;
    query_x      <= qx;
    query_health <= qh;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  task automatic pause_sender(input int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  function automatic logic [2:0] random_query_cmd;
    return ($urandom_range(1) != 0) ? CMD_FORWARD : CMD_INVERSE;
  endfunction

  // Charge breakpoints are sorted when ordered, with random spacing that may repeat a
  // value so that flat segments appear. The table rows are random or monotonic so
  // inverse queries find segments. Health breakpoints are sorted, occasionally tied.
  task automatic load_tables(input bit ordered, input bit full_range);
    logic [15:0] c;
    logic [23:0] v;
    int step;
    c = full_range ? 16'd0 : 16'($urandom_range(3000));
    for (int i = 0; i < ChargePoints; i++) begin
      send_item(CMD_LOAD_CHARGE, 3'($urandom), 4'(i), {8'($urandom), c}, 24'($urandom), 16'($urandom));
      step = ordered ? ($urandom_range(5) == 0 ? 0 : $urandom_range(full_range ? 4369 : 2000))
                     : $urandom_range(65535);
      c = ordered ? c + 16'(step) : 16'(step);
      if (full_range && i == ChargePoints - 2) c = 16'hFFFF;
    end
    c = 16'($urandom_range(4000));
    for (int i = 0; i < HealthPoints; i++) begin
      send_item(CMD_LOAD_HEALTH, 3'(i), 4'($urandom), {8'($urandom), c}, 24'($urandom), 16'($urandom));
      c = c + 16'($urandom_range(3) == 0 ? 0 : $urandom_range(4000));
    end
    for (int r = 0; r < HealthPoints; r++) begin
      v = full_range ? 24'h800000 : 24'($signed($urandom_range(200000)) - 100000);
      for (int i = 0; i < ChargePoints; i++) begin
        send_item(CMD_LOAD_TABLE, 3'(r), 4'(i), ordered ? v : 24'($urandom), 24'($urandom), 16'($urandom));
        v = v + 24'(full_range ? 24'h111111 : $urandom_range(70000));
        if (full_range && i == ChargePoints - 2) v = 24'h7FFFFF;
      end
    end
  endtask

  // Receiver stalls on its own pattern; the sender can request a long hold-off.
  initial begin
    int holds_done;
    holds_done = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests > holds_done) begin
        holds_done = hold_requests;
        out_ready <= 1'b0;
        repeat (400) @(negedge clk_i);
      end else if ($urandom_range(9) < 3) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(6)) @(negedge clk_i);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(20)) @(negedge clk_i);
      end
    end
  end

  // Watchdog: counts cycles without any transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("battery_table_interpolator_tb NOT OK");
      $finish;
    end
  end

  initial begin
    logic [2:0] cmd;
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    command       = '0;
    health_index  = '0;
    charge_index  = '0;
    load_value    = '0;
    query_x       = '0;
    query_health  = '0;
    hold_requests = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: full-range tables, then queries at the extremes of charge, voltage and
    // health, unknown commands, and ignored out-of-range loads are not possible here.
    load_tables(1'b1, 1'b1);
    send_item(CMD_FORWARD,  3'd0, 4'd0, 24'd0, 24'h800000, 16'd0);
    send_item(CMD_FORWARD,  3'd7, 4'd15, 24'hFFFFFF, 24'h7FFFFF, 16'd32768);
    send_item(CMD_FORWARD,  3'd0, 4'd0, 24'd0, 24'd16384, 16'hFFFF);
    send_item(CMD_FORWARD,  3'd0, 4'd0, 24'd0, 24'h00FFFE, 16'd2000);
    send_item(CMD_INVERSE,  3'd0, 4'd0, 24'd0, 24'h800000, 16'd0);
    send_item(CMD_INVERSE,  3'd0, 4'd0, 24'd0, 24'h7FFFFF, 16'd32768);
    send_item(CMD_INVERSE,  3'd0, 4'd0, 24'd0, 24'h000123, 16'd5000);
    send_item(CMD_INVERSE,  3'd0, 4'd0, 24'd0, 24'hC00000, 16'd9000);
    send_item(3'd5, 3'd7, 4'd15, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    send_item(3'd6, 3'd0, 4'd0, 24'd0, 24'd0, 16'd0);
    send_item(3'd7, 3'd5, 4'd10, 24'h555555, 24'hAAAAAA, 16'hAAAA);
    wait_drained;

    // Long receiver hold-off while the sender keeps offering lookups.
    hold_requests++;
    for (int i = 0; i < 6; i++)
      send_item(random_query_cmd(), 3'($urandom), 4'($urandom), 24'($urandom),
                24'($urandom), 16'($urandom));
    wait_drained;

    // Random phases: fresh tables (mostly ordered), then bursts of lookups with gaps
    // and the odd stray reload of a single entry or unknown command.
    for (int phase = 0; phase < 3; phase++) begin
      load_tables(phase != 2, 1'b0);
      for (int n = 0; n < 10; n++) begin
        repeat ($urandom_range(1, 6)) begin
          cmd = random_query_cmd();
          case ($urandom_range(9))
            0: send_item(CMD_LOAD_TABLE, 3'($urandom), 4'($urandom), 24'($urandom),
                         24'($urandom), 16'($urandom));
            1: send_item(3'($urandom_range(5, 7)), 3'($urandom), 4'($urandom),
                         24'($urandom), 24'($urandom), 16'($urandom));
            2: send_item(cmd, 3'($urandom), 4'($urandom), 24'($urandom),
                         24'($urandom), 16'($urandom));
            default: send_item(cmd, 3'($urandom), 4'($urandom), 24'($urandom),
                               cmd == CMD_FORWARD ? 24'($urandom_range(70000)) - 24'd1000
                                                  : 24'($signed($urandom_range(1500000)) - 200000),
                               16'($urandom_range(32768)));
          endcase
        end
        if ($urandom_range(3) == 0) pause_sender($urandom_range(1, 120));
      end
      wait_drained;
    end

    repeat (200) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("battery_table_interpolator_tb OK");
    end else begin
      $display("battery_table_interpolator_tb NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
sv/bti_pkg.sv
sv/bti_divider.sv
sv/battery_table_interpolator.sv
sim/battery_table_interpolator_checker.sv
sim/battery_table_interpolator_tb.sv
